// File: rtl/core/sdu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdu_pkg
// Shared widths, codes and helpers for the signal pending and delivery unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sdu_pkg;

    localparam int SIG_W  = 6;
    localparam int ADDR_W = 64;
    localparam int MODE_W = 2;
    localparam int CODE_W = 8;
    localparam int CFG_W  = 31;

    // Request codes
    localparam logic [MODE_W-1:0] MODE_SEND    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELIVER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RETURN  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INSTALL = 2'd3;

    localparam logic [SIG_W-1:0] SIG_KILL = 6'd9;
    localparam logic [SIG_W-1:0] SIG_STOP = 6'd19;

    localparam logic [ADDR_W-1:0] HANDLER_DEFAULT = 64'd0;
    localparam logic [ADDR_W-1:0] HANDLER_IGNORE  = 64'd1;

    localparam logic [ADDR_W-1:0] SP_FRAME  = 64'd8;
    localparam logic [CODE_W-1:0] EXIT_BASE = 8'd128;

    // Bit n set: the default action of signal n ends the process
    localparam logic [31:0] TERM_BY_DEFAULT = 32'hEF01_FFFE;

    typedef struct packed {
        logic load;     // capture the request on a transfer
        logic pick;     // select a signal and read its handler
        logic commit;   // update state and load the result register
    } t_dp_cmd;

    function automatic logic default_terminates(input logic [SIG_W-1:0] sig);
        logic res;
        if (sig[SIG_W-1]) begin
            res = 1'b1;
        end else begin
            res = TERM_BY_DEFAULT[sig[SIG_W-2:0]];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sdu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdu_ctrl
// Sequencer: capture a request, pick a signal, commit into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdu_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output sdu_pkg::t_dp_cmd     o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PICK = 2'd1;
    localparam logic [1:0] ST_ACT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_commit;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    // Commit only when the result register is free or being emptied
    assign w_commit    = (r_state == ST_ACT) && (!r_out_valid || i_out_ready);

    assign o_cmd.load   = i_in_valid && (r_state == ST_IDLE);
    assign o_cmd.pick   = (r_state == ST_PICK);
    assign o_cmd.commit = w_commit;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                n_state = ST_ACT;
            end
            ST_ACT: begin
                if (w_commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sdu_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdu_dp
// Datapath: pending bits, handler table, saved context and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdu_dp #(
    parameter int NUM_SIGNALS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire sdu_pkg::t_dp_cmd              i_cmd,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [sdu_pkg::CFG_W-1:0]     i_cfg_wr_data,
    input  wire logic [sdu_pkg::MODE_W-1:0]    i_mode,
    input  wire logic [sdu_pkg::SIG_W-1:0]     i_signal_number,
    input  wire logic [sdu_pkg::ADDR_W-1:0]    i_handler_address,
    input  wire logic [sdu_pkg::ADDR_W-1:0]    i_current_pc,
    input  wire logic [sdu_pkg::ADDR_W-1:0]    i_current_sp,
    output logic                               o_status,
    output logic                               o_delivered,
    output logic                               o_terminate,
    output logic [sdu_pkg::CODE_W-1:0]         o_term_code,
    output logic                               o_regs_updated,
    output logic [sdu_pkg::ADDR_W-1:0]         o_new_pc,
    output logic [sdu_pkg::ADDR_W-1:0]         o_new_sp,
    output logic [sdu_pkg::SIG_W-1:0]          o_handler_argument
);

    localparam int SW   = NUM_SIGNALS - 1;
    localparam int IDXW = $clog2(NUM_SIGNALS);
    localparam logic [IDXW-1:0]           IDX_MASK = IDXW'(NUM_SIGNALS - 1);
    localparam logic [sdu_pkg::SIG_W:0]   SIG_LIM  = (sdu_pkg::SIG_W + 1)'(NUM_SIGNALS);

    // Configuration and architectural state
    logic [sdu_pkg::CFG_W-1:0]  r_blocked;
    logic [SW-1:0]              r_pending;
    logic [SW-1:0]              n_pending;
    logic                       r_in_handler;
    logic                       n_in_handler;
    logic [sdu_pkg::ADDR_W-1:0] r_saved_pc;
    logic [sdu_pkg::ADDR_W-1:0] r_saved_sp;

    // Handler table with per-entry valid bits (invalid reads as default)
    logic [sdu_pkg::ADDR_W-1:0] mem_handler [NUM_SIGNALS];
    logic [NUM_SIGNALS-1:0]     r_tbl_vld;

    // Captured request
    logic [sdu_pkg::MODE_W-1:0] r_mode;
    logic [sdu_pkg::SIG_W-1:0]  r_sig;
    logic [sdu_pkg::ADDR_W-1:0] r_handler;
    logic [sdu_pkg::ADDR_W-1:0] r_pc;
    logic [sdu_pkg::ADDR_W-1:0] r_sp;

    // Pick stage results
    logic                       r_found;
    logic [sdu_pkg::SIG_W-1:0]  r_sel;
    logic [sdu_pkg::ADDR_W-1:0] r_rd_data;
    logic                       r_rd_vld;

    logic [SW-1:0]              w_blk;
    logic [SW-1:0]              w_ready;
    logic [sdu_pkg::SIG_W-1:0]  w_sel;
    logic                       w_sig_ok;
    logic                       w_install;
    logic [IDXW-1:0]            w_wr_idx;
    logic [sdu_pkg::ADDR_W-1:0] w_h;
    logic                       w_save;

    logic                       n_status;
    logic                       n_delivered;
    logic                       n_terminate;
    logic [sdu_pkg::CODE_W-1:0] n_term_code;
    logic                       n_regs_updated;
    logic [sdu_pkg::ADDR_W-1:0] n_new_pc;
    logic [sdu_pkg::ADDR_W-1:0] n_new_sp;
    logic [sdu_pkg::SIG_W-1:0]  n_handler_argument;

    // Lowest ready signal
    always_comb begin
        w_blk = '0;
        w_blk[sdu_pkg::CFG_W-1:0] = r_blocked;
        w_ready = r_pending & ~w_blk;
        w_sel = '0;
        for (int i = SW - 1; i >= 0; i--) begin
            if (w_ready[i]) begin
                w_sel = sdu_pkg::SIG_W'(i + 1);
            end
        end
    end

    assign w_sig_ok  = (r_sig != '0) && ({1'b0, r_sig} < SIG_LIM);
    assign w_install = (r_mode == sdu_pkg::MODE_INSTALL) && w_sig_ok &&
                       (r_sig != sdu_pkg::SIG_KILL) && (r_sig != sdu_pkg::SIG_STOP);
    assign w_wr_idx  = IDXW'(r_sig) & IDX_MASK;
    assign w_h       = r_rd_vld ? r_rd_data : sdu_pkg::HANDLER_DEFAULT;

    always_comb begin
        n_pending          = r_pending;
        n_in_handler       = r_in_handler;
        w_save             = 1'b0;
        n_status           = 1'b0;
        n_delivered        = 1'b0;
        n_terminate        = 1'b0;
        n_term_code        = '0;
        n_regs_updated     = 1'b0;
        n_new_pc           = '0;
        n_new_sp           = '0;
        n_handler_argument = '0;
        case (r_mode)
            sdu_pkg::MODE_SEND: begin
                if (w_sig_ok) begin
                    for (int i = 0; i < SW; i++) begin
                        if (r_sig == sdu_pkg::SIG_W'(i + 1)) begin
                            n_pending[i] = 1'b1;
                        end
                    end
                end else begin
                    n_status = 1'b1;
                end
            end
            sdu_pkg::MODE_DELIVER: begin
                if (!r_in_handler && r_found) begin
                    for (int i = 0; i < SW; i++) begin
                        if (r_sel == sdu_pkg::SIG_W'(i + 1)) begin
                            n_pending[i] = 1'b0;
                        end
                    end
                    if (w_h == sdu_pkg::HANDLER_IGNORE) begin
                        n_status = 1'b0;
                    end else if (w_h == sdu_pkg::HANDLER_DEFAULT) begin
                        if (sdu_pkg::default_terminates(r_sel)) begin
                            n_delivered = 1'b1;
                            n_terminate = 1'b1;
                            n_term_code = sdu_pkg::EXIT_BASE + {2'b00, r_sel};
                        end
                    end else begin
                        w_save             = 1'b1;
                        n_in_handler       = 1'b1;
                        n_delivered        = 1'b1;
                        n_regs_updated     = 1'b1;
                        n_new_pc           = w_h;
                        n_new_sp           = r_sp - sdu_pkg::SP_FRAME;
                        n_handler_argument = r_sel;
                    end
                end
            end
            sdu_pkg::MODE_RETURN: begin
                if (r_in_handler) begin
                    n_regs_updated = 1'b1;
                    n_new_pc       = r_saved_pc;
                    n_new_sp       = r_saved_sp;
                    n_in_handler   = 1'b0;
                end else begin
                    n_status = 1'b1;
                end
            end
            default: begin
                n_status = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocked    <= '0;
            r_pending    <= '0;
            r_in_handler <= 1'b0;
            r_saved_pc   <= '0;
            r_saved_sp   <= '0;
            r_tbl_vld    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_blocked <= i_cfg_wr_data;
            end
            if (i_cmd.commit) begin
                r_pending    <= n_pending;
                r_in_handler <= n_in_handler;
                if (w_save) begin
                    r_saved_pc <= r_pc;
                    r_saved_sp <= r_sp;
                end
                if (w_install) begin
                    r_tbl_vld[w_wr_idx] <= 1'b1;
                end
            end
        end
    end

    // Handler table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_install) begin
            mem_handler[w_wr_idx] <= r_handler;
        end
        if (i_cmd.pick) begin
            r_rd_data <= mem_handler[IDXW'(w_sel)];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_mode;
            r_sig     <= i_signal_number;
            r_handler <= i_handler_address;
            r_pc      <= i_current_pc;
            r_sp      <= i_current_sp;
        end
        if (i_cmd.pick) begin
            r_found  <= (w_ready != '0);
            r_sel    <= w_sel;
            r_rd_vld <= r_tbl_vld[IDXW'(w_sel)];
        end
        if (i_cmd.commit) begin
            o_status           <= n_status;
            o_delivered        <= n_delivered;
            o_terminate        <= n_terminate;
            o_term_code        <= n_term_code;
            o_regs_updated     <= n_regs_updated;
            o_new_pc           <= n_new_pc;
            o_new_sp           <= n_new_sp;
            o_handler_argument <= n_handler_argument;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/signal_pending_delivery_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signal_pending_delivery_unit
// Per-process signal pending and delivery unit, run like an interrupt
// controller.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the i_valid / o_ready channel: send, deliver, return
//   or install, selected by i_mode. Every request yields exactly one result
//   on the o_valid / i_ready channel.
//   i_cfg_wr_en writes the blocked mask at the clock edge, with no wait.
//   Write it only while no request is in flight.
//   A request passes through capture, then pick and handler-table read,
//   then commit, which loads its result into the result register.
//   The three-step sequencer owns the single handler-table read port, so
//   a new request is taken only once the previous one has committed.
//   A finished result waits in the output register; the next request is
//   taken meanwhile and holds in its commit step while the receiver stalls.
//   Reset (synchronous, active low) clears the pending bits, handler-active
//   flag, saved context and blocked mask, and marks every handler-table
//   entry as default through per-entry valid bits, so no clearing pass is
//   needed.
// ----------------------------------------------------------------------------
`default_nettype none

module signal_pending_delivery_unit #(
    parameter int NUM_SIGNALS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Request channel
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [sdu_pkg::MODE_W-1:0]    i_mode,
    input  wire logic [sdu_pkg::SIG_W-1:0]     i_signal_number,
    input  wire logic [sdu_pkg::ADDR_W-1:0]    i_handler_address,
    input  wire logic [sdu_pkg::ADDR_W-1:0]    i_current_pc,
    input  wire logic [sdu_pkg::ADDR_W-1:0]    i_current_sp,
    // Configuration
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [sdu_pkg::CFG_W-1:0]     i_cfg_wr_data,
    // Result channel
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_status,
    output logic                               o_delivered,
    output logic                               o_terminate,
    output logic [sdu_pkg::CODE_W-1:0]         o_term_code,
    output logic                               o_regs_updated,
    output logic [sdu_pkg::ADDR_W-1:0]         o_new_pc,
    output logic [sdu_pkg::ADDR_W-1:0]         o_new_sp,
    output logic [sdu_pkg::SIG_W-1:0]          o_handler_argument
);

    sdu_pkg::t_dp_cmd w_cmd;

    // Sequencer: owns the handshakes and the result-valid flag
    sdu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_cmd       (w_cmd)
    );

    // Datapath: signal state, handler table and result register
    sdu_dp #(
        .NUM_SIGNALS (NUM_SIGNALS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_mode             (i_mode),
        .i_signal_number    (i_signal_number),
        .i_handler_address  (i_handler_address),
        .i_current_pc       (i_current_pc),
        .i_current_sp       (i_current_sp),
        .o_status           (o_status),
        .o_delivered        (o_delivered),
        .o_terminate        (o_terminate),
        .o_term_code        (o_term_code),
        .o_regs_updated     (o_regs_updated),
        .o_new_pc           (o_new_pc),
        .o_new_sp           (o_new_sp),
        .o_handler_argument (o_handler_argument)
    );

endmodule

`default_nettype wire
